[rtl/core/lru_pft_pkg.sv]
// Package for the LRU page frame tracker: sizes, the per-cell control bundle
// and the configuration register index. No dependencies.
`default_nettype none

package lru_pft_pkg;

  localparam int MaxFrames = 8;
  localparam int PageBits  = 16;
  localparam int CountW    = $clog2(MaxFrames + 1);
  localparam int FcW       = 4;
  localparam int PaddrW    = 3;

  localparam logic [CountW-1:0] MaxFramesC = CountW'(MaxFrames);

  typedef logic [PageBits-1:0] page_t;
  typedef logic [CountW-1:0]   count_t;

  typedef enum logic [0:0] {
    RegFrameCount = 1'b0,
    RegUnused     = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic load;        // A beat is taken in this cycle.
    logic head;        // This cell is the most recent position.
    logic occupied;    // This cell holds a resident page.
    logic hit;         // The referenced page is resident somewhere.
    logic miss_shift;  // On a miss, this cell takes its neighbor's page.
    logic evict_sel;   // This cell holds the page that a miss evicts.
    logic tail_sel;    // This cell holds the least recent page.
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/core/lru_pft_cell.sv]
// One recency position of the LRU tracker. It compares its page against the
// reference, takes its neighbor's page on a shift and drives the select chains.
// Depends on lru_pft_pkg.
`default_nettype none

module lru_pft_cell (
  input  wire logic                  clk_i,
  input  wire lru_pft_pkg::cell_ctl_t ctl_i,
  input  wire lru_pft_pkg::page_t    ref_page_i,
  input  wire lru_pft_pkg::page_t    prev_page_i,
  input  wire logic                  seen_i,
  input  wire lru_pft_pkg::page_t    evict_i,
  input  wire lru_pft_pkg::page_t    tail_i,
  output      lru_pft_pkg::page_t    page_o,
  output      logic                  seen_o,
  output      lru_pft_pkg::page_t    evict_o,
  output      lru_pft_pkg::page_t    tail_o
);

  lru_pft_pkg::page_t page_q;
  lru_pft_pkg::page_t page_d;
  logic               match;
  logic               shift;

  always_comb begin
    match   = ctl_i.occupied && (page_q == ref_page_i);
    seen_o  = seen_i | match;
    shift   = ctl_i.head | (ctl_i.hit ? !seen_i : ctl_i.miss_shift);
    page_d  = shift ? prev_page_i : page_q;
    evict_o = evict_i | (ctl_i.evict_sel ? page_q : '0);
    tail_o  = tail_i | (ctl_i.tail_sel ? page_q : '0);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      page_q <= page_d;
    end
  end

  assign page_o = page_q;

endmodule

`default_nettype wire

[rtl/core/lru_page_frame_tracker_top.sv]
// Top level of the LRU page frame tracker: APB register, occupancy control and
// the chain of recency cells. Depends on lru_pft_pkg and lru_pft_cell.
//
// For each page reference raised on start, the cells compare and reorder at
// the edge that takes the beat, and the next cycle reads the least recent page
// out of the tail cell and presents the result for exactly one cycle on done_o,
// during which busy is high. A new beat can follow directly after that cycle.
// The receiver cannot stall the result.
`default_nettype none

module lru_page_frame_tracker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [lru_pft_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [lru_pft_pkg::PageBits-1:0] page_i,
  output      logic        done_o,
  output      logic        hit_o,
  output      logic        evict_valid_o,
  output      logic [15:0] evicted_page_o,
  output      logic [3:0]  resident_count_o,
  output      logic [15:0] oldest_page_o
);

  localparam int N = lru_pft_pkg::MaxFrames;

  logic [lru_pft_pkg::FcW-1:0] frame_count_q;
  lru_pft_pkg::count_t         occ_q, occ_d, limit, upto;
  logic                        pend_q;
  logic                        hit_q, evict_q;
  lru_pft_pkg::page_t          evicted_q;
  logic                        accept, hit, at_limit, cfg_wr;
  lru_pft_pkg::reg_idx_e       reg_idx;

  lru_pft_pkg::cell_ctl_t      ctl   [N];
  lru_pft_pkg::page_t          pages [N];
  lru_pft_pkg::page_t          prev  [N];
  logic                        seen  [N+1];
  lru_pft_pkg::page_t          evc   [N+1];
  lru_pft_pkg::page_t          tail  [N+1];

  assign pready  = 1'b1;
  assign reg_idx = lru_pft_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lru_pft_pkg::RegFrameCount: prdata = 32'(frame_count_q);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= lru_pft_pkg::FcW'(8);
    end else if (cfg_wr && reg_idx == lru_pft_pkg::RegFrameCount) begin
      frame_count_q <= pwdata[lru_pft_pkg::FcW-1:0];
    end
  end

  assign accept = start && !busy;
  assign busy   = pend_q;

  always_comb begin
    if (frame_count_q == '0) begin
      limit = lru_pft_pkg::CountW'(1);
    end else if (lru_pft_pkg::CountW'(frame_count_q) > lru_pft_pkg::MaxFramesC) begin
      limit = lru_pft_pkg::MaxFramesC;
    end else begin
      limit = lru_pft_pkg::CountW'(frame_count_q);
    end
    hit      = seen[N];
    at_limit = occ_q >= limit;
    upto     = at_limit ? limit - lru_pft_pkg::CountW'(1) : occ_q;
    if (hit) begin
      occ_d = occ_q;
    end else if (at_limit) begin
      occ_d = limit;
    end else begin
      occ_d = occ_q + lru_pft_pkg::CountW'(1);
    end
  end

  assign seen[0] = 1'b0;
  assign evc[0]  = '0;
  assign tail[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev[i] = page_i;
    end else begin : g_body
      assign prev[i] = pages[i-1];
    end

    always_comb begin
      ctl[i].load       = accept;
      ctl[i].head       = (i == 0);
      ctl[i].occupied   = lru_pft_pkg::CountW'(i) < occ_q;
      ctl[i].hit        = hit;
      ctl[i].miss_shift = lru_pft_pkg::CountW'(i) <= upto;
      ctl[i].evict_sel  = lru_pft_pkg::CountW'(i) == limit - lru_pft_pkg::CountW'(1);
      ctl[i].tail_sel   = lru_pft_pkg::CountW'(i) == occ_q - lru_pft_pkg::CountW'(1);
    end

    lru_pft_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl[i]),
      .ref_page_i  (page_i),
      .prev_page_i (prev[i]),
      .seen_i      (seen[i]),
      .evict_i     (evc[i]),
      .tail_i      (tail[i]),
      .page_o      (pages[i]),
      .seen_o      (seen[i+1]),
      .evict_o     (evc[i+1]),
      .tail_o      (tail[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= accept;
      if (accept) begin
        occ_q <= occ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q     <= hit;
      evict_q   <= !hit && at_limit;
      evicted_q <= (!hit && at_limit) ? evc[N] : '0;
    end
  end

  assign done_o           = pend_q;
  assign hit_o            = hit_q;
  assign evict_valid_o    = evict_q;
  assign evicted_page_o   = evicted_q;
  assign resident_count_o = 4'(occ_q);
  assign oldest_page_o    = tail[N];

  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy) else $error("result held longer than one cycle");

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o) else $error("accepted beat gave no result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occ_q != '0 && occ_q <= lru_pft_pkg::MaxFramesC))
    else $error("resident count out of range");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evict_valid_o) |-> (!hit_o && occ_q == $past(limit)))
    else $error("eviction on a hit or below the frame limit");

endmodule

`default_nettype wire

[tb/lru_page_frame_tracker_top_test.sv]
// Self-checking testbench for the LRU page frame tracker top level.
// Drives page references and APB frame-count writes, predicts every result beat
// in SystemVerilog and compares it field by field. Depends on lru_pft_pkg.
`timescale 1ns / 100ps

module lru_page_frame_tracker_top_test;

  localparam int IdleLimit = 4000;
  localparam int PoolMax   = 12;
  localparam int PhaseBeats = 88;

  typedef struct packed {
    logic                logic_hit_unused_guard;
  } guard_t;

  typedef struct packed {
    logic                hit;
    logic                evict_valid;
    lru_pft_pkg::page_t  evicted_page;
    logic [3:0]          resident_count;
    lru_pft_pkg::page_t  oldest_page;
  } access_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [lru_pft_pkg::PaddrW-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;
  logic                           start;
  logic                           busy;
  lru_pft_pkg::page_t             page_i;
  logic                           done_o;
  logic                           hit_o;
  logic                           evict_valid_o;
  logic [15:0]                    evicted_page_o;
  logic [3:0]                     resident_count_o;
  logic [15:0]                    oldest_page_o;

  lru_pft_pkg::page_t lru_order [lru_pft_pkg::MaxFrames];
  int                 resident;
  logic [3:0]         frame_count;
  access_t            expected_accesses [$];
  lru_pft_pkg::page_t page_pool [PoolMax];
  int                 pool_size;
  bit                 gaps_on;
  int                 failures;
  int                 idle_cycles;
  int                 pages_sent;
  int                 hits_seen;
  int                 evictions_seen;
  int                 writes_done;

  lru_page_frame_tracker_top dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .start,
    .busy,
    .page_i,
    .done_o,
    .hit_o,
    .evict_valid_o,
    .evicted_page_o,
    .resident_count_o,
    .oldest_page_o
  );

  always #5 clk_i = ~clk_i;

  function automatic access_t predict_access(lru_pft_pkg::page_t pg);
    access_t res;
    int limit;
    int pos;
    res = '0;
    if (frame_count == 4'd0) begin
      limit = 1;
    end else if (frame_count > lru_pft_pkg::MaxFrames) begin
      limit = lru_pft_pkg::MaxFrames;
    end else begin
      limit = frame_count;
    end
    pos = -1;
    for (int i = 0; i < resident; i++) begin
      if (pos < 0 && lru_order[i] == pg) begin
        pos = i;
      end
    end
    if (pos >= 0) begin
      res.hit = 1'b1;
      for (int i = pos; i > 0; i--) begin
        lru_order[i] = lru_order[i-1];
      end
    end else begin
      if (resident >= limit) begin
        res.evict_valid = 1'b1;
        res.evicted_page = lru_order[limit-1];
        resident = limit - 1;
      end
      for (int i = resident; i > 0; i--) begin
        if (i < lru_pft_pkg::MaxFrames) begin
          lru_order[i] = lru_order[i-1];
        end
      end
      resident++;
    end
    lru_order[0] = pg;
    res.resident_count = 4'(resident);
    res.oldest_page = lru_order[resident-1];
    return res;
  endfunction

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 2);
    end else if (r < 96) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic lru_pft_pkg::page_t pick_page();
    if ($urandom_range(0, 99) < 85) begin
      return page_pool[$urandom_range(0, pool_size - 1)];
    end
    return lru_pft_pkg::page_t'($urandom_range(0, 65535));
  endfunction

  task automatic refill_pool();
    pool_size = $urandom_range(3, PoolMax);
    foreach (page_pool[i]) begin
      case ($urandom_range(0, 9))
        0: page_pool[i] = 16'h0000;
        1: page_pool[i] = 16'hFFFF;
        default: page_pool[i] = lru_pft_pkg::page_t'($urandom_range(0, 65535));
      endcase
    end
  endtask

  task automatic send_page(lru_pft_pkg::page_t pg);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    page_i <= pg;
    do begin
      @(posedge clk_i);
    end while (busy);
    expected_accesses.push_back(predict_access(pg));
    pages_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_accesses.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_frame_count(logic [3:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= lru_pft_pkg::PaddrW'(4 * int'(lru_pft_pkg::RegFrameCount));
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    frame_count = value;
    writes_done++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_fill_and_evict();
    lru_pft_pkg::page_t seq [12];
    seq = '{16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF, 16'h0000, 16'h8001,
            16'h7FFE, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h1234};
    foreach (seq[i]) begin
      send_page(seq[i]);
    end
  endtask

  task automatic test_frame_limits();
    write_frame_count(4'd3);
    send_page(16'h8001);
    send_page(16'hBEEF);
    send_page(16'h8001);
    write_frame_count(4'd0);
    send_page(16'h0001);
    send_page(16'h0001);
    send_page(16'h0002);
    write_frame_count(4'd15);
    send_page(16'h0003);
    send_page(16'h0004);
  endtask

  task automatic test_random_phases();
    logic [3:0] settings [12];
    settings = '{4'd8, 4'd1, 4'd4, 4'd2, 4'd0, 4'd12, 4'd6, 4'd3, 4'd15, 4'd5,
                 4'd7, 4'd9};
    foreach (settings[p]) begin
      write_frame_count(settings[p]);
      refill_pool();
      gaps_on = (p % 3) != 2;
      repeat (PhaseBeats) send_page(pick_page());
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_accesses.size() == 0) begin
        $error("result beat with no access outstanding");
        failures++;
      end else begin
        access_t exp_res;
        exp_res = expected_accesses.pop_front();
        if (hit_o !== exp_res.hit) begin
          $error("hit: expected %0d, got %0d", exp_res.hit, hit_o);
          failures++;
        end
        if (evict_valid_o !== exp_res.evict_valid) begin
          $error("evict_valid: expected %0d, got %0d", exp_res.evict_valid, evict_valid_o);
          failures++;
        end
        if (evicted_page_o !== exp_res.evicted_page) begin
          $error("evicted_page: expected %h, got %h", exp_res.evicted_page, evicted_page_o);
          failures++;
        end
        if (resident_count_o !== exp_res.resident_count) begin
          $error("resident_count: expected %0d, got %0d", exp_res.resident_count,
                 resident_count_o);
          failures++;
        end
        if (oldest_page_o !== exp_res.oldest_page) begin
          $error("oldest_page: expected %h, got %h", exp_res.oldest_page, oldest_page_o);
          failures++;
        end
        hits_seen += exp_res.hit;
        evictions_seen += exp_res.evict_valid;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[lru_page_frame_tracker_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    page_i = '0;
    resident = 0;
    frame_count = 4'd8;
    failures = 0;
    idle_cycles = 0;
    pages_sent = 0;
    hits_seen = 0;
    evictions_seen = 0;
    writes_done = 0;
    gaps_on = 1'b1;
    foreach (lru_order[i]) lru_order[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_evict();
    test_frame_limits();
    test_random_phases();
    wait_idle();
    $display("Covered %0d page references with %0d hits and %0d evictions.",
             pages_sent, hits_seen, evictions_seen);
    $display("Frame count was written %0d times, from zero up to fifteen.", writes_done);
    if (failures == 0) begin
      $display("[lru_page_frame_tracker_top] OK");
    end else begin
      $display("[lru_page_frame_tracker_top] ERROR");
    end
    $finish;
  end

endmodule
